// ===== rtl/grwc_pkg.sv =====
// Package for the grid ray wall caster: widths, reset values, codes and the
// command and status structs between the controller and the datapath.
// No dependencies.
package grwc_pkg;

    localparam int SCREEN_WIDTH_DEF  = 320 * 4;
    localparam int SCREEN_HEIGHT_DEF = 180 * 4;
    localparam int TEX_SIZE_DEF      = 64;
    localparam int MAX_STEPS_DEF     = 16;
    localparam int MAP_SIZE          = 8;

    localparam int COL_W     = 11;
    localparam int POS_W     = 15;
    localparam int VEC_W     = 16;
    localparam int MAP_W     = 64;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 64;
    localparam int DIST_W    = 16;
    localparam int FRAC_W    = 12;
    localparam int CX_W      = 14;
    localparam int RAY_W     = 32;
    localparam int MB_W      = 18;
    localparam int PROD_W    = 50;
    localparam int DIV_W     = 32;
    localparam int DELTA_W   = 27;
    localparam int SD_W      = 48;
    localparam int GRID_W    = 4;
    localparam int RW_IN_W   = 28;
    localparam int RW_MUL_W  = 29;

    localparam int RECIP_SHIFT = 26;
    localparam int INF_SHIFT   = 40;
    localparam int ZERO_SHIFT  = 28;
    localparam int ONE_Q12     = 4096;
    localparam logic [DIST_W-1:0] DIST_MAX = 16'hFFFF;

    localparam logic [POS_W-1:0] CAM_X_RST   = 15'd4096;
    localparam logic [POS_W-1:0] CAM_Y_RST   = 15'd8192;
    localparam logic [VEC_W-1:0] DIR_X_RST   = 16'd16384;
    localparam logic [VEC_W-1:0] DIR_Y_RST   = 16'd0;
    localparam logic [VEC_W-1:0] PLANE_X_RST = 16'd0;
    localparam logic [VEC_W-1:0] PLANE_Y_RST = 16'd10813;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_CAM_X,
        REG_CAM_Y,
        REG_DIR_X,
        REG_DIR_Y,
        REG_PLANE_X,
        REG_PLANE_Y,
        REG_MAP_LO,
        REG_MAP_HI
    } cfg_reg_t;

    typedef struct packed {
        logic [POS_W-1:0] cam_x;
        logic [POS_W-1:0] cam_y;
        logic [VEC_W-1:0] dir_x;
        logic [VEC_W-1:0] dir_y;
        logic [VEC_W-1:0] plane_x;
        logic [VEC_W-1:0] plane_y;
        logic [MAP_W-1:0] map_lo;
        logic [MAP_W-1:0] map_hi;
    } cfg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_MPX,
        S_DRX,
        S_WRX,
        S_MPY,
        S_DRY,
        S_WRY,
        S_DDX,
        S_WDX,
        S_DDY,
        S_WDY,
        S_MSX,
        S_SSX,
        S_MSY,
        S_SSY,
        S_WALK,
        S_DHT,
        S_WHT,
        S_MTW,
        S_FIN
    } state_t;

    typedef enum logic [2:0] {
        MUL_PX,
        MUL_PY,
        MUL_SX,
        MUL_SY,
        MUL_TEX
    } mul_sel_t;

    typedef enum logic [2:0] {
        DIV_RX,
        DIV_RY,
        DIV_DX,
        DIV_DY,
        DIV_HT
    } div_sel_t;

    typedef struct packed {
        logic     load;
        logic     mul_en;
        mul_sel_t mul_sel;
        logic     div_start;
        logic     div_wb;
        div_sel_t div_sel;
        logic     recip_en;
        logic     sd_wb;
        logic     sd_y;
        logic     step_en;
        logic     out_load;
    } cmd_t;

    typedef struct packed {
        logic div_done;
        logic walk_end;
        logic out_full;
    } stat_t;

endpackage

// ===== rtl/grwc_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on nothing; used by the grid ray wall caster datapath.
module grwc_div #(
    parameter int W = 32
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         start,
    input  logic [W-1:0] dividend,
    input  logic [W-1:0] divisor,
    output logic         busy,
    output logic [W-1:0] quotient
);

    localparam int CNT_W = $clog2(W + 1);

    logic [W-1:0]     rem_reg, rem_next;
    logic [W-1:0]     quo_reg, quo_next;
    logic [W-1:0]     dsr_reg, dsr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic [W:0]       trial;
    logic             ge;

    assign trial = {rem_reg, quo_reg[W-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dsr_next  = dsr_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dsr_next  = divisor;
            cnt_next  = CNT_W'(W);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next  = ge ? W'(trial - {1'b0, dsr_reg}) : trial[W-1:0];
            quo_next  = {quo_reg[W-2:0], ge};
            cnt_next  = cnt_reg - CNT_W'(1);
            busy_next = cnt_reg != CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dsr_reg <= dsr_next;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/grwc_regs.sv =====
// Configuration registers of the grid ray wall caster: camera, view and map.
// Depends on grwc_pkg.
module grwc_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write,
    input  logic [grwc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [grwc_pkg::CFG_W-1:0]     cfg_data,
    output grwc_pkg::cfg_t                 cfg
);

    grwc_pkg::cfg_t cfg_reg, cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            case (grwc_pkg::cfg_reg_t'(cfg_index))
                grwc_pkg::REG_CAM_X:   cfg_next.cam_x   = cfg_data[grwc_pkg::POS_W-1:0];
                grwc_pkg::REG_CAM_Y:   cfg_next.cam_y   = cfg_data[grwc_pkg::POS_W-1:0];
                grwc_pkg::REG_DIR_X:   cfg_next.dir_x   = cfg_data[grwc_pkg::VEC_W-1:0];
                grwc_pkg::REG_DIR_Y:   cfg_next.dir_y   = cfg_data[grwc_pkg::VEC_W-1:0];
                grwc_pkg::REG_PLANE_X: cfg_next.plane_x = cfg_data[grwc_pkg::VEC_W-1:0];
                grwc_pkg::REG_PLANE_Y: cfg_next.plane_y = cfg_data[grwc_pkg::VEC_W-1:0];
                grwc_pkg::REG_MAP_LO:  cfg_next.map_lo  = cfg_data[grwc_pkg::MAP_W-1:0];
                grwc_pkg::REG_MAP_HI:  cfg_next.map_hi  = cfg_data[grwc_pkg::MAP_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.cam_x   <= grwc_pkg::CAM_X_RST;
            cfg_reg.cam_y   <= grwc_pkg::CAM_Y_RST;
            cfg_reg.dir_x   <= grwc_pkg::DIR_X_RST;
            cfg_reg.dir_y   <= grwc_pkg::DIR_Y_RST;
            cfg_reg.plane_x <= grwc_pkg::PLANE_X_RST;
            cfg_reg.plane_y <= grwc_pkg::PLANE_Y_RST;
            cfg_reg.map_lo  <= '0;
            cfg_reg.map_hi  <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/grwc_datapath.sv =====
// Datapath of the grid ray wall caster: ray setup, shared multiplier and
// divider, grid walk, slice and texture math, output register.
// Depends on grwc_pkg and grwc_div.
module grwc_datapath #(
    parameter int SCREEN_WIDTH  = grwc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = grwc_pkg::SCREEN_HEIGHT_DEF,
    parameter int TEX_SIZE      = grwc_pkg::TEX_SIZE_DEF,
    parameter int MAX_STEPS     = grwc_pkg::MAX_STEPS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  grwc_pkg::cfg_t                        cfg,
    input  grwc_pkg::cmd_t                        cmd,
    output grwc_pkg::stat_t                       stat,
    input  logic [grwc_pkg::COL_W-1:0]            column,
    input  logic                                  out_ready,
    output logic                                  out_valid,
    output logic [grwc_pkg::DIST_W-1:0]           wall_distance,
    output logic [$clog2(SCREEN_HEIGHT)-1:0]      slice_top,
    output logic [$clog2(SCREEN_HEIGHT)-1:0]      slice_bottom,
    output logic [1:0]                            wall_texture,
    output logic [$clog2(TEX_SIZE)-1:0]           texture_column,
    output logic                                  hit_side,
    output logic                                  hit_found
);

    localparam int SLICE_W = $clog2(SCREEN_HEIGHT);
    localparam int TEX_W   = $clog2(TEX_SIZE);
    localparam int STEP_W  = $clog2(MAX_STEPS);
    localparam int CX_W    = grwc_pkg::CX_W;
    localparam int RAY_W   = grwc_pkg::RAY_W;
    localparam int MB_W    = grwc_pkg::MB_W;
    localparam int PROD_W  = grwc_pkg::PROD_W;
    localparam int DIV_W   = grwc_pkg::DIV_W;
    localparam int DELTA_W = grwc_pkg::DELTA_W;
    localparam int SD_W    = grwc_pkg::SD_W;
    localparam int FRAC_W  = grwc_pkg::FRAC_W;
    localparam int DIST_W  = grwc_pkg::DIST_W;
    localparam int GRID_W  = grwc_pkg::GRID_W;
    localparam int TM_W    = FRAC_W + TEX_W + 1;
    localparam int RW_IN_W  = grwc_pkg::RW_IN_W;
    localparam int RW_MUL_W = grwc_pkg::RW_MUL_W;
    localparam int RW_SHIFT = RW_IN_W + $clog2(SCREEN_WIDTH);
    localparam logic [RW_MUL_W-1:0] RW_MUL = RW_MUL_W'(((64'd1 << RW_SHIFT) +
        64'(SCREEN_WIDTH) - 64'd1) / 64'(SCREEN_WIDTH));
    localparam logic [DIV_W-1:0] RECIP_NUM = DIV_W'(1) << grwc_pkg::RECIP_SHIFT;
    localparam logic [DIV_W-1:0] HT_NUM    = DIV_W'(SCREEN_HEIGHT) << FRAC_W;
    localparam logic [SD_W-1:0]  SD_INF    = SD_W'(1) << grwc_pkg::INF_SHIFT;

    logic signed [CX_W-1:0]   cx_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [RAY_W-1:0]  rx_reg, ry_reg;
    logic [DIV_W-1:0]         rq_reg;
    logic [DELTA_W-1:0]       dx_reg, dy_reg;
    logic [SD_W-1:0]          sdx_reg, sdy_reg;
    logic [GRID_W-1:0]        gx_reg, gy_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     side_reg, hit_reg;
    logic [1:0]               cell_reg;
    logic [DIST_W-1:0]        d_reg;
    logic [SLICE_W-1:0]       ht_reg;
    logic                     out_full_reg, out_full_next;

    logic signed [CX_W-1:0]   cx_next;
    logic signed [RAY_W-1:0]  mul_a;
    logic signed [MB_W-1:0]   mul_b;
    logic signed [PROD_W-1:0] prod_next;
    logic                     prod_neg;
    logic signed [PROD_W-1:0] prod_mag;
    logic [RW_IN_W+RW_MUL_W-1:0] rw_prod;
    logic                     rx_neg, ry_neg, rx_zero, ry_zero;
    logic [RAY_W-1:0]         rx_mag, ry_mag;
    logic [DIV_W-1:0]         div_dividend, div_divisor, quotient;
    logic                     div_busy;
    logic signed [RAY_W-1:0]  q_signed;
    logic signed [RAY_W-1:0]  ray_new;
    logic [FRAC_W:0]          fx, fy, f_sel;
    logic                     r_zero_sel;
    logic [SD_W-1:0]          sd_init;
    logic                     take_x;
    logic [SD_W-1:0]          dx_eff, dy_eff, sd_old;
    logic [GRID_W-1:0]        gx_step, gy_step, gx_n, gy_n;
    logic [2*grwc_pkg::MAP_W-1:0] map_all;
    logic [5:0]               cell_idx;
    logic [1:0]               cell_val;
    logic                     off_map, hit_now, last_step;
    logic [DIST_W-1:0]        d_next;
    logic                     near;
    logic [SLICE_W-1:0]       top_val, bottom_val;
    logic [FRAC_W-1:0]        cam_other, w_frac;
    logic [TM_W-1:0]          tmul;
    logic [TEX_W-1:0]         tex_raw, tex_val;
    logic                     mirror;

    assign cx_next = $signed({2'b00, column, 1'b0}) - $signed(CX_W'(SCREEN_WIDTH));

    always_comb
    begin
        case (cmd.mul_sel)
            grwc_pkg::MUL_PX:
            begin
                mul_a = RAY_W'($signed(cfg.plane_x));
                mul_b = MB_W'(cx_reg);
            end
            grwc_pkg::MUL_PY:
            begin
                mul_a = RAY_W'($signed(cfg.plane_y));
                mul_b = MB_W'(cx_reg);
            end
            grwc_pkg::MUL_SX:
            begin
                mul_a = RAY_W'(dx_reg);
                mul_b = MB_W'(fx);
            end
            grwc_pkg::MUL_SY:
            begin
                mul_a = RAY_W'(dy_reg);
                mul_b = MB_W'(fy);
            end
            grwc_pkg::MUL_TEX:
            begin
                mul_a = side_reg ? rx_reg : ry_reg;
                mul_b = MB_W'(d_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = mul_a * mul_b;

    assign prod_neg = prod_reg[PROD_W-1];
    assign prod_mag = prod_neg ? -prod_reg : prod_reg;
    assign rx_neg   = rx_reg[RAY_W-1];
    assign ry_neg   = ry_reg[RAY_W-1];
    assign rx_zero  = rx_reg == '0;
    assign ry_zero  = ry_reg == '0;
    assign rx_mag   = rx_neg ? RAY_W'(-rx_reg) : RAY_W'(rx_reg);
    assign ry_mag   = ry_neg ? RAY_W'(-ry_reg) : RAY_W'(ry_reg);

    // The division by the screen width is a multiply by a rounded-up
    // reciprocal, exact for every product magnitude below 2^RW_IN_W.
    assign rw_prod = prod_mag[RW_IN_W-1:0] * RW_MUL;

    always_comb
    begin
        case (cmd.div_sel)
            grwc_pkg::DIV_DX:
            begin
                div_dividend = RECIP_NUM;
                div_divisor  = rx_mag;
            end
            grwc_pkg::DIV_DY:
            begin
                div_dividend = RECIP_NUM;
                div_divisor  = ry_mag;
            end
            grwc_pkg::DIV_HT:
            begin
                div_dividend = HT_NUM;
                div_divisor  = DIV_W'(d_reg);
            end
            default:
            begin
                div_dividend = '0;
                div_divisor  = '0;
            end
        endcase
    end

    grwc_div #(
        .W(DIV_W)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .busy     (div_busy),
        .quotient (quotient)
    );

    assign q_signed = prod_neg ? -$signed(rq_reg) : $signed(rq_reg);
    assign ray_new  = (cmd.div_sel == grwc_pkg::DIV_RX) ?
                      RAY_W'($signed(cfg.dir_x)) + q_signed :
                      RAY_W'($signed(cfg.dir_y)) + q_signed;

    assign fx = rx_neg ? {1'b0, cfg.cam_x[FRAC_W-1:0]} :
                (FRAC_W+1)'(grwc_pkg::ONE_Q12) - {1'b0, cfg.cam_x[FRAC_W-1:0]};
    assign fy = ry_neg ? {1'b0, cfg.cam_y[FRAC_W-1:0]} :
                (FRAC_W+1)'(grwc_pkg::ONE_Q12) - {1'b0, cfg.cam_y[FRAC_W-1:0]};
    assign f_sel      = cmd.sd_y ? fy : fx;
    assign r_zero_sel = cmd.sd_y ? ry_zero : rx_zero;
    assign sd_init    = r_zero_sel ? (SD_W'(f_sel) << grwc_pkg::ZERO_SHIFT) :
                        SD_W'(prod_reg[PROD_W-1:FRAC_W]);

    assign take_x  = sdx_reg < sdy_reg;
    assign dx_eff  = rx_zero ? SD_INF : SD_W'(dx_reg);
    assign dy_eff  = ry_zero ? SD_INF : SD_W'(dy_reg);
    assign gx_step = rx_neg ? gx_reg - GRID_W'(1) : gx_reg + GRID_W'(1);
    assign gy_step = ry_neg ? gy_reg - GRID_W'(1) : gy_reg + GRID_W'(1);
    assign gx_n    = take_x ? gx_step : gx_reg;
    assign gy_n    = take_x ? gy_reg : gy_step;
    assign off_map = gx_n[GRID_W-1] | gy_n[GRID_W-1];
    assign map_all  = {cfg.map_hi, cfg.map_lo};
    assign cell_idx = {gx_n[2:0], gy_n[2:0]};
    assign cell_val = map_all[{cell_idx, 1'b0} +: 2];
    assign hit_now  = !off_map && (cell_val != 2'd0);
    assign last_step = step_reg == STEP_W'(MAX_STEPS - 1);
    assign sd_old   = take_x ? sdx_reg : sdy_reg;
    assign d_next   = (sd_old > SD_W'(grwc_pkg::DIST_MAX)) ? grwc_pkg::DIST_MAX :
                      sd_old[DIST_W-1:0];

    assign near       = d_reg <= DIST_W'(grwc_pkg::ONE_Q12);
    assign top_val    = near ? '0 : SLICE_W'(SCREEN_HEIGHT / 2) - (ht_reg >> 1);
    assign bottom_val = near ? SLICE_W'(SCREEN_HEIGHT - 1) :
                        SLICE_W'(SCREEN_HEIGHT / 2) + (ht_reg >> 1);

    assign cam_other = side_reg ? cfg.cam_x[FRAC_W-1:0] : cfg.cam_y[FRAC_W-1:0];
    assign w_frac    = cam_other + prod_reg[FRAC_W+2 +: FRAC_W];
    assign tmul      = TM_W'(w_frac) * TM_W'(TEX_SIZE);
    assign tex_raw   = tmul[FRAC_W +: TEX_W];
    assign mirror    = side_reg ? ry_neg : (!rx_neg && !rx_zero);
    assign tex_val   = mirror ? TEX_W'(TEX_SIZE - 1) - tex_raw : tex_raw;

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            cx_reg   <= cx_next;
            gx_reg   <= {1'b0, cfg.cam_x[grwc_pkg::POS_W-1:FRAC_W]};
            gy_reg   <= {1'b0, cfg.cam_y[grwc_pkg::POS_W-1:FRAC_W]};
            step_reg <= '0;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.recip_en)
        begin
            rq_reg <= DIV_W'(rw_prod >> RW_SHIFT);
        end
        if (cmd.div_wb)
        begin
            case (cmd.div_sel)
                grwc_pkg::DIV_RX: rx_reg <= ray_new;
                grwc_pkg::DIV_RY: ry_reg <= ray_new;
                grwc_pkg::DIV_DX: dx_reg <= quotient[DELTA_W-1:0];
                grwc_pkg::DIV_DY: dy_reg <= quotient[DELTA_W-1:0];
                grwc_pkg::DIV_HT: ht_reg <= quotient[SLICE_W-1:0];
                default:          ht_reg <= ht_reg;
            endcase
        end
        if (cmd.sd_wb)
        begin
            if (cmd.sd_y)
            begin
                sdy_reg <= sd_init;
            end
            else
            begin
                sdx_reg <= sd_init;
            end
        end
        if (cmd.step_en)
        begin
            if (take_x)
            begin
                sdx_reg <= sdx_reg + dx_eff;
            end
            else
            begin
                sdy_reg <= sdy_reg + dy_eff;
            end
            gx_reg   <= gx_n;
            gy_reg   <= gy_n;
            step_reg <= step_reg + STEP_W'(1);
            side_reg <= !take_x;
            hit_reg  <= hit_now;
            cell_reg <= cell_val;
            d_reg    <= d_next;
        end
        if (cmd.out_load)
        begin
            if (hit_reg)
            begin
                wall_distance  <= d_reg;
                slice_top      <= top_val;
                slice_bottom   <= bottom_val;
                wall_texture   <= cell_reg - 2'd1;
                texture_column <= tex_val;
                hit_side       <= side_reg;
                hit_found      <= 1'b1;
            end
            else
            begin
                wall_distance  <= grwc_pkg::DIST_MAX;
                slice_top      <= '0;
                slice_bottom   <= '0;
                wall_texture   <= '0;
                texture_column <= '0;
                hit_side       <= 1'b0;
                hit_found      <= 1'b0;
            end
        end
    end

    always_comb
    begin
        out_full_next = out_full_reg;
        if (out_full_reg && out_ready)
        begin
            out_full_next = 1'b0;
        end
        if (cmd.out_load)
        begin
            out_full_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_full_reg <= 1'b0;
        end
        else
        begin
            out_full_reg <= out_full_next;
        end
    end

    assign out_valid     = out_full_reg;
    assign stat.div_done = !div_busy;
    assign stat.walk_end = off_map | hit_now | last_step;
    assign stat.out_full = out_full_reg;

endmodule

// ===== rtl/grwc_ctrl.sv =====
// Controller of the grid ray wall caster: sequences setup, divisions, the
// grid walk and the result hand-off. Depends on grwc_pkg.
module grwc_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  grwc_pkg::stat_t stat,
    output grwc_pkg::cmd_t  cmd
);

    grwc_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= grwc_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        cmd         = '0;
        cmd.mul_sel = grwc_pkg::MUL_PX;
        cmd.div_sel = grwc_pkg::DIV_RX;
        in_ready    = 1'b0;
        case (state_reg)
            grwc_pkg::S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = grwc_pkg::S_MPX;
                end
            end
            grwc_pkg::S_MPX:
            begin
                cmd.mul_en = 1'b1;
                state_next = grwc_pkg::S_DRX;
            end
            grwc_pkg::S_DRX:
            begin
                cmd.recip_en = 1'b1;
                state_next   = grwc_pkg::S_WRX;
            end
            grwc_pkg::S_WRX:
            begin
                cmd.div_wb = 1'b1;
                state_next = grwc_pkg::S_MPY;
            end
            grwc_pkg::S_MPY:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = grwc_pkg::MUL_PY;
                state_next  = grwc_pkg::S_DRY;
            end
            grwc_pkg::S_DRY:
            begin
                cmd.recip_en = 1'b1;
                cmd.div_sel  = grwc_pkg::DIV_RY;
                state_next   = grwc_pkg::S_WRY;
            end
            grwc_pkg::S_WRY:
            begin
                cmd.div_sel = grwc_pkg::DIV_RY;
                cmd.div_wb  = 1'b1;
                state_next  = grwc_pkg::S_DDX;
            end
            grwc_pkg::S_DDX:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = grwc_pkg::DIV_DX;
                state_next    = grwc_pkg::S_WDX;
            end
            grwc_pkg::S_WDX:
            begin
                cmd.div_sel = grwc_pkg::DIV_DX;
                if (stat.div_done)
                begin
                    cmd.div_wb = 1'b1;
                    state_next = grwc_pkg::S_DDY;
                end
            end
            grwc_pkg::S_DDY:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = grwc_pkg::DIV_DY;
                state_next    = grwc_pkg::S_WDY;
            end
            grwc_pkg::S_WDY:
            begin
                cmd.div_sel = grwc_pkg::DIV_DY;
                if (stat.div_done)
                begin
                    cmd.div_wb = 1'b1;
                    state_next = grwc_pkg::S_MSX;
                end
            end
            grwc_pkg::S_MSX:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = grwc_pkg::MUL_SX;
                state_next  = grwc_pkg::S_SSX;
            end
            grwc_pkg::S_SSX:
            begin
                cmd.sd_wb  = 1'b1;
                state_next = grwc_pkg::S_MSY;
            end
            grwc_pkg::S_MSY:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = grwc_pkg::MUL_SY;
                state_next  = grwc_pkg::S_SSY;
            end
            grwc_pkg::S_SSY:
            begin
                cmd.sd_wb  = 1'b1;
                cmd.sd_y   = 1'b1;
                state_next = grwc_pkg::S_WALK;
            end
            grwc_pkg::S_WALK:
            begin
                cmd.step_en = 1'b1;
                if (stat.walk_end)
                begin
                    state_next = grwc_pkg::S_DHT;
                end
            end
            grwc_pkg::S_DHT:
            begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = grwc_pkg::DIV_HT;
                state_next    = grwc_pkg::S_WHT;
            end
            grwc_pkg::S_WHT:
            begin
                cmd.div_sel = grwc_pkg::DIV_HT;
                if (stat.div_done)
                begin
                    cmd.div_wb = 1'b1;
                    state_next = grwc_pkg::S_MTW;
                end
            end
            grwc_pkg::S_MTW:
            begin
                cmd.mul_en  = 1'b1;
                cmd.mul_sel = grwc_pkg::MUL_TEX;
                state_next  = grwc_pkg::S_FIN;
            end
            grwc_pkg::S_FIN:
            begin
                if (!stat.out_full)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = grwc_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = grwc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/grid_ray_wall_caster.sv =====
// Top level of the grid ray wall caster: DDA ray casting through an 8x8 map.
// Depends on grwc_pkg, grwc_regs, grwc_ctrl and grwc_datapath.
//
//  Channel   Handshake              Carries
//  in        in_valid / in_ready    column
//  out       out_valid / out_ready  wall_distance .. hit_found
//  cfg       cfg_write              cfg_index, cfg_data
//
// A column walks 1 to MAX_STEPS grid steps. Three divisions share one radix-2
// divider, and the two ray divisions by the screen width are products.
// Columns are worked one at a time; the next is taken while a result waits.
// Reset is asynchronous and active low; configuration registers return to their defaults.
// A stalled output holds its result; the next finished column then waits before loading it.
module grid_ray_wall_caster #(
    parameter int SCREEN_WIDTH  = grwc_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = grwc_pkg::SCREEN_HEIGHT_DEF,
    parameter int TEX_SIZE      = grwc_pkg::TEX_SIZE_DEF,
    parameter int MAX_STEPS     = grwc_pkg::MAX_STEPS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_write,
    input  logic [grwc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [grwc_pkg::CFG_W-1:0]        cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [grwc_pkg::COL_W-1:0]        column,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [grwc_pkg::DIST_W-1:0]       wall_distance,
    output logic [$clog2(SCREEN_HEIGHT)-1:0]  slice_top,
    output logic [$clog2(SCREEN_HEIGHT)-1:0]  slice_bottom,
    output logic [1:0]                        wall_texture,
    output logic [$clog2(TEX_SIZE)-1:0]       texture_column,
    output logic                              hit_side,
    output logic                              hit_found
);

    grwc_pkg::cfg_t  cfg;
    grwc_pkg::cmd_t  cmd;
    grwc_pkg::stat_t stat;

    grwc_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    grwc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    grwc_datapath #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .TEX_SIZE      (TEX_SIZE),
        .MAX_STEPS     (MAX_STEPS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg),
        .cmd            (cmd),
        .stat           (stat),
        .column         (column),
        .out_ready      (out_ready),
        .out_valid      (out_valid),
        .wall_distance  (wall_distance),
        .slice_top      (slice_top),
        .slice_bottom   (slice_bottom),
        .wall_texture   (wall_texture),
        .texture_column (texture_column),
        .hit_side       (hit_side),
        .hit_found      (hit_found)
    );

endmodule

// ===== rtl/grwc_checker.sv =====
// Port-level checks of the grid ray wall caster, bound to the top level.
// Depends on grwc_pkg and grid_ray_wall_caster.
module grwc_checker #(
    parameter int SCREEN_HEIGHT = grwc_pkg::SCREEN_HEIGHT_DEF
) (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_ready,
    input logic                             out_valid,
    input logic                             out_ready,
    input logic [grwc_pkg::DIST_W-1:0]      wall_distance,
    input logic [$clog2(SCREEN_HEIGHT)-1:0] slice_top,
    input logic [$clog2(SCREEN_HEIGHT)-1:0] slice_bottom,
    input logic [1:0]                       wall_texture,
    input logic                             hit_side,
    input logic                             hit_found
);

    localparam int SLICE_W = $clog2(SCREEN_HEIGHT);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(wall_distance))
        else $error("Result changed or vanished while stalled.");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("A second request was taken while one is in work.");

    a_miss_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !hit_found |-> wall_distance == grwc_pkg::DIST_MAX &&
        slice_top == '0 && slice_bottom == '0 && wall_texture == 2'd0 && !hit_side)
        else $error("Miss result is not in its fixed form.");

    a_hit_texture: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit_found |-> wall_texture != 2'd3)
        else $error("Hit reports an empty cell texture.");

    a_near_slice: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && hit_found && wall_distance <= 16'd4096 |->
        slice_top == '0 && slice_bottom == SLICE_W'(SCREEN_HEIGHT - 1))
        else $error("Near wall does not fill the column.");

endmodule

bind grid_ray_wall_caster grwc_checker #(
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_grwc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .wall_distance (wall_distance),
    .slice_top     (slice_top),
    .slice_bottom  (slice_bottom),
    .wall_texture  (wall_texture),
    .hit_side      (hit_side),
    .hit_found     (hit_found)
);

// ===== tb/tb_grid_ray_wall_caster.sv =====
// Testbench for grid_ray_wall_caster: drives column requests under random idling,
// predicts each wall hit with an independent DDA walk and checks every result.
// Depends on grwc_pkg and the grid_ray_wall_caster RTL.
`timescale 1ns / 100ps

class wall_hit_board;
    logic [15:0] exp_dist[$];
    logic [9:0]  exp_top[$];
    logic [9:0]  exp_bot[$];
    logic [1:0]  exp_tex[$];
    logic [5:0]  exp_tcol[$];
    logic        exp_side[$];
    logic        exp_hit[$];
    int          errors;

    logic [14:0] cam_x, cam_y;
    logic [15:0] dir_x, dir_y, plane_x, plane_y;
    logic [63:0] map_lo, map_hi;

    function new();
        errors = 0;
        cam_x = grwc_pkg::CAM_X_RST;
        cam_y = grwc_pkg::CAM_Y_RST;
        dir_x = grwc_pkg::DIR_X_RST;
        dir_y = grwc_pkg::DIR_Y_RST;
        plane_x = grwc_pkg::PLANE_X_RST;
        plane_y = grwc_pkg::PLANE_Y_RST;
        map_lo = '0;
        map_hi = '0;
    endfunction

    function void set_reg(grwc_pkg::cfg_reg_t idx, logic [63:0] v);
        case (idx)
            grwc_pkg::REG_CAM_X:   cam_x = v[14:0];
            grwc_pkg::REG_CAM_Y:   cam_y = v[14:0];
            grwc_pkg::REG_DIR_X:   dir_x = v[15:0];
            grwc_pkg::REG_DIR_Y:   dir_y = v[15:0];
            grwc_pkg::REG_PLANE_X: plane_x = v[15:0];
            grwc_pkg::REG_PLANE_Y: plane_y = v[15:0];
            grwc_pkg::REG_MAP_LO:  map_lo = v;
            default:               map_hi = v;
        endcase
    endfunction

    function longint delta_of(longint r);
        longint a;
        if (r == 0)
            return longint'(1) << 40;
        a = (r < 0) ? -r : r;
        return (longint'(1) << 26) / a;
    endfunction

    function longint floor14(longint p);
        if (p >= 0)
            return p >>> 14;
        return -((-p + 16383) >>> 14);
    endfunction

    function void note_column(logic [10:0] col);
        longint cxv, rx, ry, gx, gy, dx, dy, sdx, sdy, perp, d, h, top, bot, w, t, fx, fy;
        int side, n;
        logic [1:0] cell_v;
        logic hit;
        cxv = 2 * longint'(col) - 1280;
        rx = longint'($signed(dir_x)) + (longint'($signed(plane_x)) * cxv) / 1280;
        ry = longint'($signed(dir_y)) + (longint'($signed(plane_y)) * cxv) / 1280;
        gx = longint'(cam_x >> 12);
        gy = longint'(cam_y >> 12);
        dx = delta_of(rx);
        dy = delta_of(ry);
        fx = longint'(cam_x[11:0]);
        fy = longint'(cam_y[11:0]);
        if (rx >= 0)
            fx = 4096 - fx;
        if (ry >= 0)
            fy = 4096 - fy;
        sdx = (dx * fx) >>> 12;
        sdy = (dy * fy) >>> 12;
        side = 0;
        cell_v = 2'd0;
        hit = 1'b0;
        for (n = 0; n < grwc_pkg::MAX_STEPS_DEF; n++)
        begin
            if (sdx < sdy)
            begin
                sdx += dx;
                gx += (rx < 0) ? -1 : 1;
                side = 0;
            end
            else
            begin
                sdy += dy;
                gy += (ry < 0) ? -1 : 1;
                side = 1;
            end
            if (gx < 0 || gx > 7 || gy < 0 || gy > 7)
                break;
            if (gx < 4)
                cell_v = map_lo[2 * (gx * 8 + gy) +: 2];
            else
                cell_v = map_hi[2 * ((gx - 4) * 8 + gy) +: 2];
            if (cell_v != 2'd0)
            begin
                hit = 1'b1;
                break;
            end
        end
        if (!hit)
        begin
            push(16'hFFFF, 10'd0, 10'd0, 2'd0, 6'd0, 1'b0, 1'b0);
            return;
        end
        perp = (side == 0) ? sdx - dx : sdy - dy;
        d = (perp > 65535) ? 65535 : perp;
        if (d <= 4096)
        begin
            top = 0;
            bot = 719;
        end
        else
        begin
            h = (720 * 4096) / d;
            top = 360 - h / 2;
            bot = 360 + h / 2;
        end
        if (side == 0)
            w = longint'(cam_y) + floor14(d * ry);
        else
            w = longint'(cam_x) + floor14(d * rx);
        t = ((w & 12'hFFF) * 64) >> 12;
        if ((side == 0 && rx > 0) || (side == 1 && ry < 0))
            t = 63 - t;
        push(d[15:0], top[9:0], bot[9:0], cell_v - 2'd1, t[5:0], side[0], 1'b1);
    endfunction

    function void push(logic [15:0] d, logic [9:0] tp, logic [9:0] bt, logic [1:0] tx,
                       logic [5:0] tc, logic sd, logic ht);
        exp_dist.push_back(d);
        exp_top.push_back(tp);
        exp_bot.push_back(bt);
        exp_tex.push_back(tx);
        exp_tcol.push_back(tc);
        exp_side.push_back(sd);
        exp_hit.push_back(ht);
    endfunction

    function int pending();
        return exp_dist.size();
    endfunction

    function void check_result(logic [15:0] d, logic [9:0] tp, logic [9:0] bt,
                               logic [1:0] tx, logic [5:0] tc, logic sd, logic ht);
        logic [15:0] ed;
        logic [9:0] et, eb;
        logic [1:0] ex;
        logic [5:0] ec;
        logic es, eh;
        if (exp_dist.size() == 0)
        begin
            $display("%0t unexpected result: distance %h", $time, d);
            errors++;
            return;
        end
        ed = exp_dist.pop_front();
        et = exp_top.pop_front();
        eb = exp_bot.pop_front();
        ex = exp_tex.pop_front();
        ec = exp_tcol.pop_front();
        es = exp_side.pop_front();
        eh = exp_hit.pop_front();
        if (d !== ed) begin $display("%0t wall_distance exp %h got %h", $time, ed, d); errors++; end
        if (tp !== et) begin $display("%0t slice_top exp %0d got %0d", $time, et, tp); errors++; end
        if (bt !== eb) begin $display("%0t slice_bottom exp %0d got %0d", $time, eb, bt); errors++; end
        if (tx !== ex) begin $display("%0t wall_texture exp %0d got %0d", $time, ex, tx); errors++; end
        if (tc !== ec) begin $display("%0t texture_column exp %0d got %0d", $time, ec, tc); errors++; end
        if (sd !== es) begin $display("%0t hit_side exp %0d got %0d", $time, es, sd); errors++; end
        if (ht !== eh) begin $display("%0t hit_found exp %0d got %0d", $time, eh, ht); errors++; end
    endfunction
endclass

module tb_grid_ray_wall_caster;

    logic              clk;
    logic              rst_n;
    logic              cfg_write;
    logic [2:0]        cfg_index;
    logic [63:0]       cfg_data;
    logic              in_valid;
    logic              in_ready;
    logic [10:0]       column;
    logic              out_valid;
    logic              out_ready;
    logic [15:0]       wall_distance;
    logic [9:0]        slice_top;
    logic [9:0]        slice_bottom;
    logic [1:0]        wall_texture;
    logic [5:0]        texture_column;
    logic              hit_side;
    logic              hit_found;

    wall_hit_board board;
    bit                calm;
    int                hold_off;

    grid_ray_wall_caster u_dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .column(column),
        .out_valid(out_valid), .out_ready(out_ready),
        .wall_distance(wall_distance), .slice_top(slice_top), .slice_bottom(slice_bottom),
        .wall_texture(wall_texture), .texture_column(texture_column),
        .hit_side(hit_side), .hit_found(hit_found)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            board.check_result(wall_distance, slice_top, slice_bottom, wall_texture,
                               texture_column, hit_side, hit_found);
    end

    // The receiver stalls in random bursts, or for a long stretch when asked.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                out_ready <= 1'b0;
                hold_off--;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                gap = $urandom_range(1, 7);
                out_ready <= 1'b0;
                repeat (gap - 1) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    task automatic write_reg(grwc_pkg::cfg_reg_t idx, logic [63:0] v);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= v;
        board.set_reg(idx, v);
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_column(logic [10:0] col);
        if (!calm && $urandom_range(0, 3) == 0)
            repeat ($urandom_range(1, 7)) @(posedge clk);
        in_valid <= 1'b1;
        column <= col;
        do @(posedge clk); while (!in_ready);
        board.note_column(col);
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain();
        while (board.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Sparse random walls with a closed border keep most rays hitting something.
    function automatic logic [63:0] walled_map(bit high_half);
        logic [63:0] m;
        int x, y, xx;
        m = '0;
        for (x = 0; x < 4; x++)
            for (y = 0; y < 8; y++)
            begin
                xx = high_half ? x + 4 : x;
                if (xx == 0 || xx == 7 || y == 0 || y == 7 || $urandom_range(0, 5) == 0)
                    m[2 * (x * 8 + y) +: 2] = 2'($urandom_range(1, 3));
            end
        return m;
    endfunction

    task automatic random_view();
        write_reg(grwc_pkg::REG_CAM_X, 64'($urandom_range(4096, 28671)));
        write_reg(grwc_pkg::REG_CAM_Y, 64'($urandom_range(4096, 28671)));
        write_reg(grwc_pkg::REG_DIR_X, 64'($urandom_range(0, 65535)));
        write_reg(grwc_pkg::REG_DIR_Y, 64'($urandom_range(0, 65535)));
        write_reg(grwc_pkg::REG_PLANE_X, 64'($urandom_range(0, 65535)));
        write_reg(grwc_pkg::REG_PLANE_Y, 64'($urandom_range(0, 65535)));
        if ($urandom_range(0, 4) == 0)
        begin
            write_reg(grwc_pkg::REG_MAP_LO, rand64());
            write_reg(grwc_pkg::REG_MAP_HI, rand64());
        end
        else
        begin
            write_reg(grwc_pkg::REG_MAP_LO, walled_map(1'b0));
            write_reg(grwc_pkg::REG_MAP_HI, walled_map(1'b1));
        end
    endtask

    initial
    begin
        #20000000;
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int i, k;
        board = new();
        calm = 0;
        hold_off = 0;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        column = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset view with an empty map: rays leave the map.
        send_column(11'd0);
        send_column(11'd640);
        send_column(11'd1279);
        drain();

        write_reg(grwc_pkg::REG_MAP_LO, 64'hFFFF_FFFF_FFFF_FFFF);
        write_reg(grwc_pkg::REG_MAP_HI, 64'hAAAA_5555_AAAA_5555);
        send_column(11'd0);
        send_column(11'd1279);
        send_column(11'd2047);
        send_column(11'd1024);
        drain();

        // Camera in a corner cell looking out of the map, so every ray leaves it on its first step.
        write_reg(grwc_pkg::REG_MAP_LO, 64'h0000_0000_0000_0003);
        write_reg(grwc_pkg::REG_MAP_HI, 64'h0);
        write_reg(grwc_pkg::REG_CAM_X, 64'h7FFF);
        write_reg(grwc_pkg::REG_CAM_Y, 64'd0);
        write_reg(grwc_pkg::REG_DIR_X, 64'h8000);
        write_reg(grwc_pkg::REG_DIR_Y, 64'h8000);
        write_reg(grwc_pkg::REG_PLANE_X, 64'h7FFF);
        write_reg(grwc_pkg::REG_PLANE_Y, 64'h0);
        send_column(11'd0);
        send_column(11'd640);
        send_column(11'd1279);
        send_column(11'd2047);
        drain();

        // Axis rays with zero components, tiny rays for saturated distance.
        write_reg(grwc_pkg::REG_MAP_LO, walled_map(1'b0));
        write_reg(grwc_pkg::REG_MAP_HI, walled_map(1'b1));
        write_reg(grwc_pkg::REG_CAM_X, 64'd16384);
        write_reg(grwc_pkg::REG_CAM_Y, 64'd16384);
        write_reg(grwc_pkg::REG_DIR_X, 64'd1);
        write_reg(grwc_pkg::REG_DIR_Y, 64'd0);
        write_reg(grwc_pkg::REG_PLANE_X, 64'd0);
        write_reg(grwc_pkg::REG_PLANE_Y, 64'd0);
        send_column(11'd640);
        drain();
        write_reg(grwc_pkg::REG_DIR_Y, 64'h7FFF);
        write_reg(grwc_pkg::REG_DIR_X, 64'h0);
        send_column(11'd640);
        drain();
        write_reg(grwc_pkg::REG_PLANE_Y, 64'h7FFF);
        send_column(11'd0);
        send_column(11'd1279);
        send_column(11'd1365);
        drain();

        // Long receiver stall while the sender keeps offering requests.
        hold_off = 400;
        for (k = 0; k < 6; k++)
            send_column(11'($urandom_range(0, 1279)));
        drain();

        for (i = 0; i < 640; i++)
        begin
            if (i % 40 == 0)
            begin
                drain();
                random_view();
            end
            if (i == 560)
                calm = 1;
            if ($urandom_range(0, 9) == 0)
                send_column(11'($urandom_range(0, 2047)));
            else
                send_column(11'($urandom_range(0, 1279)));
        end
        drain();

        if (board.errors == 0 && board.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule
